>>> hdl/epr_pkg.sv
package epr_pkg;

    localparam int EPR_COORD_W = 24;
    localparam int EPR_COEF_W  = 16;
    localparam int CFG_IDX_W   = 3;

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COS_X = 3'd0,
        CFG_SIN_X = 3'd1,
        CFG_COS_Y = 3'd2,
        CFG_SIN_Y = 3'd3,
        CFG_COS_Z = 3'd4,
        CFG_SIN_Z = 3'd5
    } t_cfg_reg;

endpackage

>>> hdl/epr_point_in_if.sv
interface epr_point_in_if #(
    parameter int CW = epr_pkg::EPR_COORD_W
);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] x_in;
    logic signed [CW-1:0] y_in;
    logic signed [CW-1:0] z_in;

    modport source (output valid, output x_in, output y_in, output z_in, input ready);
    modport sink   (input valid, input x_in, input y_in, input z_in, output ready);
endinterface

>>> hdl/epr_point_out_if.sv
interface epr_point_out_if #(
    parameter int CW = epr_pkg::EPR_COORD_W
);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] x_out;
    logic signed [CW-1:0] y_out;
    logic signed [CW-1:0] z_out;
    logic                 clipped;

    modport source (output valid, output x_out, output y_out, output z_out,
                    output clipped, input ready);
    modport sink   (input valid, input x_out, input y_out, input z_out,
                    input clipped, output ready);
endinterface

>>> hdl/epr_rot.sv
// one planar rotation: p = a*c - b*s, q = a*s + b*c, rounded and saturated
// stage 1 registers the four products, stage 2 the rounded sums
module epr_rot #(
    parameter int CW = epr_pkg::EPR_COORD_W,
    parameter int KW = epr_pkg::EPR_COEF_W
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic signed [CW-1:0] i_a,
    input  logic signed [CW-1:0] i_b,
    input  logic signed [CW-1:0] i_pass,
    input  logic                 i_clip,
    input  logic signed [KW-1:0] i_cos,
    input  logic signed [KW-1:0] i_sin,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic signed [CW-1:0] o_p,
    output logic signed [CW-1:0] o_q,
    output logic signed [CW-1:0] o_pass,
    output logic                 o_clip
);
    localparam int PW = CW + KW;
    localparam int SW = PW + 2;
    localparam int F  = KW - 2;
    localparam int RW = CW + 4;
    localparam logic signed [SW-1:0] RND  = {{(SW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
    localparam logic signed [RW-1:0] MAXV = {{(RW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [RW-1:0] MINV = {{(RW-CW+1){1'b1}}, {(CW-1){1'b0}}};

    // returns {saturated, value}
    function automatic logic [CW:0] rnd_sat(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] t;
        logic signed [RW-1:0] r;
        t = (v + RND) >>> F;
        r = t[RW-1:0];
        if (r > MAXV) begin
            rnd_sat = {1'b1, 1'b0, {(CW-1){1'b1}}};
        end else if (r < MINV) begin
            rnd_sat = {1'b1, 1'b1, {(CW-1){1'b0}}};
        end else begin
            rnd_sat = {1'b0, r[CW-1:0]};
        end
    endfunction

    logic                 r_v1;
    logic signed [PW-1:0] r_pac;
    logic signed [PW-1:0] r_pbs;
    logic signed [PW-1:0] r_pas;
    logic signed [PW-1:0] r_pbc;
    logic signed [CW-1:0] r_pass1;
    logic                 r_clip1;

    logic                 r_v2;
    logic signed [CW-1:0] r_p;
    logic signed [CW-1:0] r_q;
    logic signed [CW-1:0] r_pass2;
    logic                 r_clip2;

    logic                 ready1;
    logic                 ready2;
    logic signed [SW-1:0] ext_ac, ext_bs, ext_as, ext_bc;
    logic signed [SW-1:0] dif, sum;
    logic [CW:0]          n_p, n_q;

    assign ready2     = !r_v2 || i_out_ready;
    assign ready1     = !r_v1 || ready2;
    assign o_in_ready = ready1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (ready1) begin
            r_v1 <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready1 && i_in_valid) begin
            r_pac   <= i_a * i_cos;
            r_pbs   <= i_b * i_sin;
            r_pas   <= i_a * i_sin;
            r_pbc   <= i_b * i_cos;
            r_pass1 <= i_pass;
            r_clip1 <= i_clip;
        end
    end

    always_comb begin
        ext_ac = {{(SW-PW){r_pac[PW-1]}}, r_pac};
        ext_bs = {{(SW-PW){r_pbs[PW-1]}}, r_pbs};
        ext_as = {{(SW-PW){r_pas[PW-1]}}, r_pas};
        ext_bc = {{(SW-PW){r_pbc[PW-1]}}, r_pbc};
        dif    = ext_ac - ext_bs;
        sum    = ext_as + ext_bc;
        n_p    = rnd_sat(dif);
        n_q    = rnd_sat(sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (ready2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready2 && r_v1) begin
            r_p     <= n_p[CW-1:0];
            r_q     <= n_q[CW-1:0];
            r_pass2 <= r_pass1;
            r_clip2 <= r_clip1 | n_p[CW] | n_q[CW];
        end
    end

    assign o_out_valid = r_v2;
    assign o_p         = r_p;
    assign o_q         = r_q;
    assign o_pass      = r_pass2;
    assign o_clip      = r_clip2;

    // an accepted request lands in the product stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_v1)
        else $error("accepted request not held in product stage");

    // a stalled result stays put
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && !i_out_ready |=> r_v2 && $stable(r_p) && $stable(r_q) && $stable(r_clip2))
        else $error("stalled result lost or changed");

    // products move forward when stage 2 has room
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && ready2 |=> r_v2)
        else $error("product stage item dropped");

    // an earlier clip is never dropped
    a_clip_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && r_clip1 && ready2 |=> r_clip2)
        else $error("clip flag lost between stages");

endmodule

>>> hdl/euler_point_rotation_top.sv
// Rotates a stream of 3D points (signed Q16.8) about X, then Y, then Z, using
// cosine/sine pairs (signed Q1.14) held in six configuration registers. Each
// rotation is two pipeline stages (multiply, then sum/round/saturate), and one
// point can enter every cycle while the output is not stalled; the rate is set
// by the twelve multipliers, each used once per point. Stalls on the output back
// up stage by stage, and bubbles inside the pipe are filled while the output
// waits. Sums round to nearest (ties toward +inf) and saturate to the coordinate
// range; clipped flags any saturation, including intermediate ones. Write
// coefficients only while the pipe is empty.
module euler_point_rotation_top #(
    parameter int COORD_WIDTH = epr_pkg::EPR_COORD_W,
    parameter int COEF_WIDTH  = epr_pkg::EPR_COEF_W
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [epr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COEF_WIDTH-1:0]        i_cfg_data,
    epr_point_in_if.sink                 i_pt,
    epr_point_out_if.source              o_pt
);
    // 1.0 in the coefficient format
    localparam logic signed [COEF_WIDTH-1:0] COEF_ONE = {2'b01, {(COEF_WIDTH-2){1'b0}}};

    // coefficient registers
    logic signed [COEF_WIDTH-1:0] r_cos_x, r_sin_x;
    logic signed [COEF_WIDTH-1:0] r_cos_y, r_sin_y;
    logic signed [COEF_WIDTH-1:0] r_cos_z, r_sin_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos_x <= COEF_ONE;
            r_sin_x <= '0;
            r_cos_y <= COEF_ONE;
            r_sin_y <= '0;
            r_cos_z <= COEF_ONE;
            r_sin_z <= '0;
        end else if (i_cfg_we) begin
            // indexes past the list are ignored
            unique case (i_cfg_idx)
                epr_pkg::CFG_COS_X: r_cos_x <= i_cfg_data;
                epr_pkg::CFG_SIN_X: r_sin_x <= i_cfg_data;
                epr_pkg::CFG_COS_Y: r_cos_y <= i_cfg_data;
                epr_pkg::CFG_SIN_Y: r_sin_y <= i_cfg_data;
                epr_pkg::CFG_COS_Z: r_cos_z <= i_cfg_data;
                epr_pkg::CFG_SIN_Z: r_sin_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // handshake between rotation units
    logic xv, xr, yv, yr;
    // X rotation results: y1, z1, x carried along
    logic signed [COORD_WIDTH-1:0] y1, z1, xc;
    logic                          clip_x;
    // Y rotation results: x2, z2, y1 carried along
    logic signed [COORD_WIDTH-1:0] x2, z2, y1c;
    logic                          clip_y;

    // about X: y1 = y*cx - z*sx, z1 = y*sx + z*cx
    epr_rot #(.CW(COORD_WIDTH), .KW(COEF_WIDTH)) u_rot_x (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pt.valid),
        .o_in_ready  (i_pt.ready),
        .i_a         (i_pt.y_in),
        .i_b         (i_pt.z_in),
        .i_pass      (i_pt.x_in),
        .i_clip      (1'b0),
        .i_cos       (r_cos_x),
        .i_sin       (r_sin_x),
        .o_out_valid (xv),
        .i_out_ready (xr),
        .o_p         (y1),
        .o_q         (z1),
        .o_pass      (xc),
        .o_clip      (clip_x)
    );

    // about Y: x2 = x*cy - z1*sy, z2 = x*sy + z1*cy
    epr_rot #(.CW(COORD_WIDTH), .KW(COEF_WIDTH)) u_rot_y (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (xv),
        .o_in_ready  (xr),
        .i_a         (xc),
        .i_b         (z1),
        .i_pass      (y1),
        .i_clip      (clip_x),
        .i_cos       (r_cos_y),
        .i_sin       (r_sin_y),
        .o_out_valid (yv),
        .i_out_ready (yr),
        .o_p         (x2),
        .o_q         (z2),
        .o_pass      (y1c),
        .o_clip      (clip_y)
    );

    // about Z: x3 = x2*cz - y1*sz, y3 = x2*sz + y1*cz, z2 carried to the output
    epr_rot #(.CW(COORD_WIDTH), .KW(COEF_WIDTH)) u_rot_z (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (yv),
        .o_in_ready  (yr),
        .i_a         (x2),
        .i_b         (y1c),
        .i_pass      (z2),
        .i_clip      (clip_y),
        .i_cos       (r_cos_z),
        .i_sin       (r_sin_z),
        .o_out_valid (o_pt.valid),
        .i_out_ready (o_pt.ready),
        .o_p         (o_pt.x_out),
        .o_q         (o_pt.y_out),
        .o_pass      (o_pt.z_out),
        .o_clip      (o_pt.clipped)
    );

endmodule

>>> tb/tb_euler_point_rotation_top.sv
`timescale 1ns / 100ps

module tb_euler_point_rotation_top;

    localparam int CLK_HALF     = 2;
    localparam int FRAC_BITS    = epr_pkg::EPR_COEF_W - 2;
    localparam longint ROUND_HALF = longint'(1) <<< (FRAC_BITS - 1);
    localparam longint COORD_HI = (longint'(1) <<< (epr_pkg::EPR_COORD_W - 1)) - 1;
    localparam longint COORD_LO = -COORD_HI - 1;
    localparam int WATCHDOG_CYCLES = 5000;
    localparam int DRAIN_CYCLES    = 12;
    localparam int PHASES          = 9;
    localparam int PHASE_POINTS    = 110;

    typedef logic [epr_pkg::CFG_IDX_W-1:0]  t_idx;
    typedef logic [epr_pkg::EPR_COEF_W-1:0] t_coef;

    // the index field is 3 bits wide, so two writes land on no register
    localparam t_idx CFG_SPARE_6 = 3'd6;
    localparam t_idx CFG_SPARE_7 = 3'd7;

    // Q1.14 coefficient codes used by the directed part
    localparam t_coef COEF_ONE      = 16'sd16384;
    localparam t_coef COEF_NEG_ONE  = -16'sd16384;
    localparam t_coef COEF_HALF     = 16'sd8192;
    localparam t_coef COEF_ZERO     = 16'sd0;
    localparam t_coef COEF_MOST_NEG = 16'h8000;
    localparam t_coef COEF_MOST_POS = 16'h7FFF;

    typedef logic signed [epr_pkg::EPR_COORD_W-1:0] t_coord;

    localparam t_coord PT_MAX = t_coord'(COORD_HI);
    localparam t_coord PT_MIN = t_coord'(COORD_LO);

    typedef struct {
        t_coord x;
        t_coord y;
        t_coord z;
        logic   clipped;
    } t_point;

    // coefficient copy, rotation predictor and queue of rotated points in flight
    class rotation_book;
        longint cos_x, sin_x, cos_y, sin_y, cos_z, sin_z;
        t_point rotated_q[$];
        int     mismatches;
        int     points_noted;
        int     results_seen;
        int     clipped_noted;

        function new();
            cos_x = 1 <<< FRAC_BITS; sin_x = 0;
            cos_y = 1 <<< FRAC_BITS; sin_y = 0;
            cos_z = 1 <<< FRAC_BITS; sin_z = 0;
            mismatches    = 0;
            points_noted  = 0;
            results_seen  = 0;
            clipped_noted = 0;
        endfunction

        function void write_coef(t_idx idx, t_coef data);
            longint v;
            v = longint'($signed(data));
            case (idx)
                epr_pkg::CFG_COS_X: cos_x = v;
                epr_pkg::CFG_SIN_X: sin_x = v;
                epr_pkg::CFG_COS_Y: cos_y = v;
                epr_pkg::CFG_SIN_Y: sin_y = v;
                epr_pkg::CFG_COS_Z: cos_z = v;
                epr_pkg::CFG_SIN_Z: sin_z = v;
                default: ;
            endcase
        endfunction

        // a*c + b*d, rounded half up at the Q1.14 point, clamped to the coordinate range
        function longint rotate_term(longint a, longint c, longint b, longint d,
                                     inout bit sat);
            longint acc;
            acc = (a * c + b * d + ROUND_HALF) >>> FRAC_BITS;
            if (acc > COORD_HI) begin
                sat = 1'b1;
                acc = COORD_HI;
            end else if (acc < COORD_LO) begin
                sat = 1'b1;
                acc = COORD_LO;
            end
            return acc;
        endfunction

        function void note_point(t_coord px, t_coord py, t_coord pz);
            longint x, y, z, y1, z1, x2, z2, x3, y3;
            bit     sat;
            t_point want;
            sat = 1'b0;
            x = longint'(px);
            y = longint'(py);
            z = longint'(pz);
            y1 = rotate_term(y,  cos_x, z,  -sin_x, sat);
            z1 = rotate_term(y,  sin_x, z,   cos_x, sat);
            x2 = rotate_term(x,  cos_y, z1, -sin_y, sat);
            z2 = rotate_term(x,  sin_y, z1,  cos_y, sat);
            x3 = rotate_term(x2, cos_z, y1, -sin_z, sat);
            y3 = rotate_term(x2, sin_z, y1,  cos_z, sat);
            want.x       = x3[epr_pkg::EPR_COORD_W-1:0];
            want.y       = y3[epr_pkg::EPR_COORD_W-1:0];
            want.z       = z2[epr_pkg::EPR_COORD_W-1:0];
            want.clipped = sat;
            rotated_q.push_back(want);
            points_noted++;
            if (sat) clipped_noted++;
        endfunction

        function void report(string what, t_point want, t_point got);
            mismatches++;
            if (mismatches <= 10)
                $display({"%0t mismatch (%s): expected x=%0d y=%0d z=%0d clip=%0b,",
                          " got x=%0d y=%0d z=%0d clip=%0b"},
                         $time, what, want.x, want.y, want.z, want.clipped,
                         got.x, got.y, got.z, got.clipped);
        endfunction

        function void check_result(t_point got);
            t_point want;
            results_seen++;
            if (rotated_q.size() == 0) begin
                report("no point pending", got, got);
                return;
            end
            want = rotated_q.pop_front();
            if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
                got.clipped !== want.clipped)
                report("rotated point", want, got);
        endfunction

        function int pending();
            return rotated_q.size();
        endfunction
    endclass

    logic  i_clk;
    logic  i_rst_n;
    logic  cfg_we;
    t_idx  cfg_idx;
    t_coef cfg_data;

    epr_point_in_if  pt_in_if ();
    epr_point_out_if pt_out_if ();

    euler_point_rotation_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_pt       (pt_in_if),
        .o_pt       (pt_out_if)
    );

    rotation_book book = new();

    // idle odds of each side in percent, and a receiver hold-off counted down on its own
    int send_idle_pct;
    int recv_idle_pct;
    int recv_hold_cycles;
    int coef_settings;

    initial i_clk = 1'b0;
    always #CLK_HALF i_clk = ~i_clk;

    // receiver: ready changes only on the falling edge
    initial begin
        pt_out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (recv_hold_cycles > 0) begin
                pt_out_if.ready = 1'b0;
                recv_hold_cycles--;
            end else begin
                pt_out_if.ready = ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // result monitor: values are taken at the rising edge before the block updates them
    always @(posedge i_clk) begin
        t_point got;
        if (i_rst_n && pt_out_if.valid === 1'b1 && pt_out_if.ready) begin
            got.x       = pt_out_if.x_out;
            got.y       = pt_out_if.y_out;
            got.z       = pt_out_if.z_out;
            got.clipped = pt_out_if.clipped;
            book.check_result(got);
        end
    end

    // watchdog: ends the run after a long stretch with no request or result moving
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_CYCLES) begin
            @(posedge i_clk);
            if ((pt_in_if.valid && pt_in_if.ready) || (pt_out_if.valid && pt_out_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t no progress for %0d cycles, %0d points still pending",
                 $time, WATCHDOG_CYCLES, book.pending());
        $display("[euler_point_rotation_top] ERROR");
        $finish;
    end

    // one register write; the block must hold no points at this moment
    task automatic write_coef(t_idx idx, t_coef data);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        book.write_coef(idx, data);
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    task automatic write_rotation(t_coef cx, t_coef sx, t_coef cy, t_coef sy,
                                  t_coef cz, t_coef sz);
        write_coef(epr_pkg::CFG_COS_X, cx);
        write_coef(epr_pkg::CFG_SIN_X, sx);
        write_coef(epr_pkg::CFG_COS_Y, cy);
        write_coef(epr_pkg::CFG_SIN_Y, sy);
        write_coef(epr_pkg::CFG_COS_Z, cz);
        write_coef(epr_pkg::CFG_SIN_Z, sz);
        coef_settings++;
    endtask

    // hold the sender until every rotated point has come back
    task automatic wait_drain();
        pt_in_if.valid = 1'b0;
        while (book.pending() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    // offer one point, with random idle cycles ahead of it; called and left on a falling edge
    task automatic send_point(t_coord x, t_coord y, t_coord z);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            pt_in_if.valid = 1'b0;
            @(negedge i_clk);
        end
        pt_in_if.valid = 1'b1;
        pt_in_if.x_in  = x;
        pt_in_if.y_in  = y;
        pt_in_if.z_in  = z;
        do @(posedge i_clk); while (pt_in_if.ready !== 1'b1);
        book.note_point(x, y, z);
        @(negedge i_clk);
    endtask

    // mostly small and mid-range coordinates so that many points stay unclipped
    function automatic t_coord rand_coord();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            return t_coord'($urandom);
        else if (pick < 7)
            return t_coord'($urandom_range(0, 8191)) - t_coord'(4096);
        else
            return t_coord'($urandom_range(0, 2097151)) - t_coord'(1048576);
    endfunction

    function automatic t_coef rand_coef(int kind);
        case (kind)
            0: return t_coef'($urandom_range(0, 32768) - 16384);    // within +-1.0
            1: return t_coef'($urandom);                           // any 16-bit pattern
            default: begin
                case ($urandom_range(0, 4))
                    0: return COEF_MOST_NEG;
                    1: return COEF_MOST_POS;
                    2: return COEF_ONE;
                    3: return COEF_NEG_ONE;
                    default: return COEF_ZERO;
                endcase
            end
        endcase
    endfunction

    initial begin
        cfg_we           = 1'b0;
        cfg_idx          = epr_pkg::CFG_COS_X;
        cfg_data         = '0;
        pt_in_if.valid   = 1'b0;
        pt_in_if.x_in    = '0;
        pt_in_if.y_in    = '0;
        pt_in_if.z_in    = '0;
        recv_hold_cycles = 0;
        coef_settings    = 0;
        send_idle_pct    = 9;
        recv_idle_pct    = 75;
        i_rst_n          = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // identity after reset: extremes pass through untouched
        send_point(0, 0, 0);
        send_point(PT_MAX, PT_MAX, PT_MAX);
        send_point(PT_MIN, PT_MIN, PT_MIN);
        send_point(PT_MAX, PT_MIN, 1);
        send_point(-1, 256, -256);

        // writes to the two unused indexes must leave the rotation alone
        wait_drain();
        write_coef(CFG_SPARE_6, COEF_MOST_NEG);
        write_coef(CFG_SPARE_7, COEF_MOST_POS);
        send_point(1000, -2000, 3000);

        // coefficients of -2.0: out-of-range values taken as written, heavy clipping
        wait_drain();
        write_rotation(COEF_MOST_NEG, COEF_MOST_NEG, COEF_MOST_NEG,
                       COEF_MOST_NEG, COEF_MOST_NEG, COEF_MOST_NEG);
        send_point(PT_MAX, PT_MIN, 0);
        send_point(1, 1, 1);
        send_point(PT_MIN, PT_MIN, PT_MIN);

        // largest positive code, unnormalized pairs
        wait_drain();
        write_rotation(COEF_MOST_POS, COEF_MOST_POS, COEF_MOST_POS,
                       COEF_MOST_POS, COEF_MOST_POS, COEF_MOST_POS);
        send_point(PT_MAX, PT_MAX, PT_MAX);
        send_point(-5, 7, -9);

        // halving on X: odd coordinates land on exact ties, which go toward +inf
        wait_drain();
        write_rotation(COEF_HALF, COEF_ZERO, COEF_ONE, COEF_ZERO, COEF_ONE, COEF_ZERO);
        send_point(1, 1, 1);
        send_point(-1, -1, -1);
        send_point(3, -3, 5);

        // quarter turns both ways about every axis
        wait_drain();
        write_rotation(COEF_ZERO, COEF_ONE, COEF_ZERO, COEF_ONE, COEF_ZERO, COEF_ONE);
        send_point(100, 200, 300);
        send_point(PT_MAX, 0, PT_MIN);
        wait_drain();
        write_rotation(COEF_ZERO, COEF_NEG_ONE, COEF_ZERO, COEF_NEG_ONE,
                       COEF_ZERO, COEF_NEG_ONE);
        send_point(PT_MIN, PT_MAX, 1);

        // random phases: a fresh coefficient set each, idling pattern per third
        for (int p = 0; p < PHASES; p++) begin
            wait_drain();
            if (p < PHASES / 3) begin
                send_idle_pct = 9;
                recv_idle_pct = 75;
            end else if (p < 2 * PHASES / 3) begin
                send_idle_pct = 75;
                recv_idle_pct = 9;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_rotation(rand_coef(p % 3), rand_coef(p % 3), rand_coef(p % 3),
                           rand_coef(p % 3), rand_coef(p % 3), rand_coef(p % 3));
            for (int k = 0; k < PHASE_POINTS; k++) begin
                // long output stall while requests keep coming: the pipe fills and
                // backs up into the input
                if (p == 1 && k == 20) recv_hold_cycles = 180;
                // sender pause until the pipe is empty, coefficients unchanged
                if (p == 4 && k == 55) wait_drain();
                send_point(rand_coord(), rand_coord(), rand_coord());
            end
        end

        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("rotated %0d points (%0d with clipping) under %0d coefficient sets",
                 book.points_noted, book.clipped_noted, coef_settings);
        $display("results compared: %0d, mismatches: %0d, still pending: %0d",
                 book.results_seen, book.mismatches, book.pending());
        if (book.mismatches == 0 && book.pending() == 0)
            $display("[euler_point_rotation_top] OK");
        else
            $display("[euler_point_rotation_top] ERROR");
        $finish;
    end

endmodule
